[rtl/seo_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seo_pkg
// Shared types and constants for the strided element offset core.
// ----------------------------------------------------------------------------
package seo_pkg;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_OVF   = 2'd2,
		ST_AXES  = 2'd3
	} seo_status_t;

	// Entries in the front-to-back queue; power of two
	localparam int QUEUE_DEPTH = 8;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Config register indexes
	localparam logic REG_BASE_OFFSET = 1'b0;

	// Classified axis term, handed from front to back
	typedef struct packed {
		logic        first;     // first axis of an element
		logic        too_many;  // axis beyond the axis limit
		logic        last;      // final axis, produces a result
		logic        in_range;  // index < extent
		logic        mul_ovf;   // |stride| * index >= 2^64
		logic        neg;       // stride is negative, subtract term
		logic [63:0] term;      // |stride| * index
	} seo_item_t;

endpackage

[rtl/seo_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seo_front
// Accepts axis transactions, tracks the axis count, checks the index range
// and forms |stride| * index in a three-stage 32x32 partial-product pipeline.
// ----------------------------------------------------------------------------
module seo_front
	import seo_pkg::*;
#(
	parameter int MAX_AXES = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [191:0] s_tdata,   // axis_index, axis_extent, axis_stride
	input  logic         s_tlast,   // last_axis
	input  logic         q_pop,
	output logic         q_push,
	output seo_item_t    q_item
);

	localparam int AX_W = $clog2(MAX_AXES + 1);

	logic [AX_W-1:0]   axes_q;
	logic [QCNT_W-1:0] credit_q;
	logic              accept;

	logic [63:0] idx_in, ext_in, str_in, mag_in;

	// stage 1: registered operands
	logic        vld_s1;
	logic        first_s1, many_s1, last_s1, rng_s1, neg_s1;
	logic [63:0] mag_s1, idx_s1;

	// stage 2: partial products
	logic        vld_s2;
	logic        first_s2, many_s2, last_s2, rng_s2, neg_s2, hh_nz_s2;
	logic [63:0] ll_s2, hl_s2, lh_s2;

	// stage 3: product and overflow
	logic        vld_s3;
	seo_item_t   item_s3;
	logic [65:0] mid;

	assign idx_in = s_tdata[63:0];
	assign ext_in = s_tdata[127:64];
	assign str_in = s_tdata[191:128];
	assign mag_in = str_in[63] ? (~str_in + 64'd1) : str_in;

	// Credit: items in flight plus items queued never exceed the queue depth
	assign s_tready = (credit_q < QCNT_W'(QUEUE_DEPTH));
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
		end else begin
			unique case ({accept, q_pop})
				2'b10:   credit_q <= credit_q + QCNT_W'(1);
				2'b01:   credit_q <= credit_q - QCNT_W'(1);
				default: credit_q <= credit_q;
			endcase
		end
	end

	// Axis counter saturates at MAX_AXES, clears after the last axis
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axes_q <= '0;
		end else if (accept) begin
			if (s_tlast) begin
				axes_q <= '0;
			end else if (axes_q < AX_W'(MAX_AXES)) begin
				axes_q <= axes_q + AX_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			first_s1 <= (axes_q == '0);
			many_s1  <= (axes_q >= AX_W'(MAX_AXES));
			last_s1  <= s_tlast;
			rng_s1   <= (idx_in < ext_in);
			neg_s1   <= str_in[63];
			mag_s1   <= mag_in;
			idx_s1   <= idx_in;
		end
	end

	always_ff @(posedge clk) begin
		first_s2 <= first_s1;
		many_s2  <= many_s1;
		last_s2  <= last_s1;
		rng_s2   <= rng_s1;
		neg_s2   <= neg_s1;
		hh_nz_s2 <= (|mag_s1[63:32]) && (|idx_s1[63:32]);
		ll_s2    <= mag_s1[31:0]  * idx_s1[31:0];
		hl_s2    <= mag_s1[63:32] * idx_s1[31:0];
		lh_s2    <= mag_s1[31:0]  * idx_s1[63:32];
	end

	// product = mid * 2^32 + ll[31:0]; overflow when mid needs more than 32 bits
	assign mid = {2'b00, hl_s2} + {2'b00, lh_s2} + {34'd0, ll_s2[63:32]};

	always_ff @(posedge clk) begin
		item_s3.first    <= first_s2;
		item_s3.too_many <= many_s2;
		item_s3.last     <= last_s2;
		item_s3.in_range <= rng_s2;
		item_s3.neg      <= neg_s2;
		item_s3.mul_ovf  <= hh_nz_s2 || (|mid[65:32]);
		item_s3.term     <= {mid[31:0], ll_s2[31:0]};
	end

	assign q_push = vld_s3;
	assign q_item = item_s3;

endmodule

[rtl/seo_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seo_queue
// Small FIFO of classified axis terms between front and back.
// ----------------------------------------------------------------------------
module seo_queue
	import seo_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  seo_item_t push_item,
	input  logic      pop,
	output logic      empty,
	output seo_item_t head
);

	seo_item_t         mem [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QCNT_W-1:0] cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + QPTR_W'(1);
			if (pop)  rd_q <= rd_q + QPTR_W'(1);
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
				2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign empty = (cnt_q == '0);
	assign head  = mem[rd_q];

endmodule

[rtl/seo_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seo_back
// Accumulates axis terms into the running offset with sticky status and
// holds the finished result in an output register.
// ----------------------------------------------------------------------------
module seo_back
	import seo_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic [63:0] base_offset,
	input  logic        q_empty,
	input  seo_item_t   q_head,
	output logic        q_pop,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // byte_offset_out
	output logic [1:0]  m_tuser    // status
);

	logic [63:0] run_q;
	seo_status_t st_q;
	logic        out_vld_q;
	logic [63:0] out_off_q;
	seo_status_t out_st_q;

	logic [63:0] run_in, run_nx;
	seo_status_t st_in, st_nx;
	logic [64:0] sum;

	assign q_pop = !q_empty && (!q_head.last || !out_vld_q || m_tready);

	always_comb begin
		run_in = q_head.first ? base_offset : run_q;
		st_in  = q_head.first ? ST_OK : st_q;
		sum    = {1'b0, run_in} + {1'b0, q_head.term};
		run_nx = run_in;
		st_nx  = st_in;
		if (q_head.too_many) begin
			st_nx = ST_AXES;
		end else if (st_in == ST_OK) begin
			priority if (!q_head.in_range) begin
				st_nx = ST_RANGE;
			end else if (q_head.mul_ovf) begin
				st_nx = ST_OVF;
			end else if (!q_head.neg) begin
				if (sum[64]) st_nx = ST_OVF;
				else         run_nx = sum[63:0];
			end else begin
				if (run_in < q_head.term) st_nx = ST_RANGE;
				else                      run_nx = run_in - q_head.term;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= '0;
			st_q  <= ST_OK;
		end else if (q_pop) begin
			if (q_head.last) begin
				run_q <= '0;
				st_q  <= ST_OK;
			end else begin
				run_q <= run_nx;
				st_q  <= st_nx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (q_pop && q_head.last) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && q_head.last) begin
			out_off_q <= (st_nx == ST_OK) ? run_nx : 64'd0;
			out_st_q  <= st_nx;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_off_q;
	assign m_tuser  = out_st_q;

endmodule

[rtl/strided_element_offset_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strided_element_offset_core
// Strided tensor view element byte offset, one axis per cycle when ready.
// ----------------------------------------------------------------------------
// One axis transaction per clock when ready: s_tdata carries index, extent
// and signed stride, s_tlast the element's last axis. The offset starts at
// the base_offset register (APB, address 0, 64-bit) on each element's first
// axis and then adds index*stride per axis (subtracts for negative strides).
// When the last axis is processed one result leaves on the m_ side: offset
// in m_tdata (zero unless status is OK) and status in m_tuser
// (0 ok, 1 index out of range or offset below zero, 2 multiply/add overflow,
// 3 more than MAX_AXES axes; the first error sticks, too-many-axes wins).
// Throughput is one axis per cycle, sustained while s_tready is high. On
// the way from input accept to the result on m_tvalid, the operand
// register loads at the accepting edge, then come the 32x32 partial
// products, the product sum and overflow check, the queue write, and the
// back-end accumulator, which does one 64-bit add or subtract per cycle
// while it may pop, and writes the output register. An eight-entry queue
// sits between front and back; s_tready drops only when that queue plus
// the front pipeline holds eight axes, which happens when m_tready is held
// low. The output register lets the back end keep taking non-last axes
// while a result waits. base_offset should be written only while idle.
// ----------------------------------------------------------------------------
module strided_element_offset_core
	import seo_pkg::*;
#(
	parameter int MAX_AXES = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	// axis input stream
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [191:0] s_tdata,   // [63:0] axis_index, [127:64] axis_extent,
	                                // [191:128] axis_stride
	input  logic         s_tlast,   // last_axis
	// result stream
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [63:0]  m_tdata,   // [63:0] byte_offset_out
	output logic [1:0]   m_tuser,   // [1:0] status
	// config port
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [63:0]  pwdata,
	output logic [63:0]  prdata,
	output logic         pready
);

	logic [63:0] base_q;
	logic        q_push, q_pop, q_empty;
	seo_item_t   q_in, q_head;

	// Register index comes from paddr[3]; only index 0 exists
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (psel && penable && pwrite && pready
		             && (paddr[3] == REG_BASE_OFFSET)) begin
			base_q <= pwdata;
		end
	end

	assign prdata = (paddr[3] == REG_BASE_OFFSET) ? base_q : 64'd0;

	// Front: accept, range check, axis count, |stride| * index
	seo_front #(
		.MAX_AXES (MAX_AXES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.q_pop    (q_pop),
		.q_push   (q_push),
		.q_item   (q_in)
	);

	seo_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_in),
		.pop       (q_pop),
		.empty     (q_empty),
		.head      (q_head)
	);

	// Back: running offset, sticky status, result register
	seo_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.base_offset (base_q),
		.q_empty     (q_empty),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser)
	);

endmodule
